// ===== rtl/rtsp_pkg.sv =====
// rtsp_pkg: shared widths, codes and reset values of the resistive touch
// sample processor. no dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package rtsp_pkg;

  // field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned WordW   = 16;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 3 * CoordW;

  // accumulators and scaling
  localparam int unsigned SumW    = 20;
  localparam int unsigned SumShift = 3;
  localparam int unsigned ScaledW = SumW - SumShift;
  localparam int unsigned ProdW   = ScaledW + CoordW;
  localparam int unsigned AdcBits = 12;
  localparam int unsigned QuotW   = ProdW - AdcBits;
  localparam logic [CoordW-1:0] AdcFullScale = CoordW'(1 << AdcBits);

  localparam int unsigned SamplePairsDef = 4;

  // register reset values
  localparam logic [CoordW-1:0] PressThresholdRst = 16'd600;
  localparam logic [CoordW-1:0] WidthMaxRst       = 16'd320;
  localparam logic [CoordW-1:0] HeightMaxRst      = 16'd240;

  typedef enum logic [OpW-1:0] {
    OP_Z1 = 2'd0,
    OP_Z2 = 2'd1,
    OP_X  = 2'd2,
    OP_Y  = 2'd3
  } opcode_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_PRESS_THRESHOLD = 3'd0,
    REG_WIDTH_MAX       = 3'd1,
    REG_HEIGHT_MAX      = 3'd2,
    REG_SWAP_AXES       = 3'd3,
    REG_MIRROR_H        = 3'd4,
    REG_MIRROR_V        = 3'd5
  } cfg_index_e;

endpackage

`default_nettype wire

// ===== rtl/resistive_touch_sample_processor.sv =====
// resistive_touch_sample_processor: turns tagged converter words into touch
// reports (pressure check, x/y averaging, scaling, swap and mirror).
// depends on rtsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tuser opcode, tdata raw_word
//  m_axis   | out       | m_axis_tvalid/tready   | tuser touched, tdata pos_x/y/pressure
//  cfg      | in        | cfg_we_i (no wait)     | cfg_addr_i index, cfg_wdata_i value
//
//  one request accepted per cycle while the pipeline is not frozen; the word that ends
//  a frame passes input reg, frame update, axis multiply, 1/N multiply, output reg
//  the pipeline moves as one: m_axis_tready low with a report waiting freezes
//  every stage, so s_axis_tready follows the output register
//  reset clears frame state, valid bits and the config registers to defaults

module resistive_touch_sample_processor #(
  parameter int unsigned SAMPLE_PAIRS = rtsp_pkg::SamplePairsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // stream in
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [rtsp_pkg::WordW-1:0]    s_axis_tdata,  // [15:0] raw_word
  input  wire logic [rtsp_pkg::OpW-1:0]      s_axis_tuser,  // [1:0] opcode
  // stream out
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [rtsp_pkg::OutDataW-1:0] m_axis_tdata,  // [15:0] pos_x, [31:16] pos_y,
                                                            // [47:32] pressure
  output      logic                          m_axis_tuser,  // [0] touched
  // config write port
  input  wire logic                          cfg_we_i,
  input  wire logic [rtsp_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [rtsp_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rtsp_pkg::*;

  // pair counter only has to reach SAMPLE_PAIRS
  localparam int unsigned PairW = $clog2(SAMPLE_PAIRS + 1);
  localparam logic [PairW-1:0] PairsLast = PairW'(SAMPLE_PAIRS);

  // floor(a / N) as (a * Recip) >> RecipShift, exact for every a below 2^QuotW
  localparam int unsigned RecipShift = QuotW + $clog2(SAMPLE_PAIRS);
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(SAMPLE_PAIRS) - 64'd1) / 64'(SAMPLE_PAIRS));
  localparam int unsigned RecipProdW = QuotW + RecipW;

  // config registers
  logic [CoordW-1:0] thr_q, width_max_q, height_max_q;
  logic              swap_q, mirror_h_q, mirror_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= PressThresholdRst;
      width_max_q  <= WidthMaxRst;
      height_max_q <= HeightMaxRst;
      swap_q       <= 1'b0;
      mirror_h_q   <= 1'b0;
      mirror_v_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_addr_i))
        REG_PRESS_THRESHOLD: thr_q        <= cfg_wdata_i[CoordW-1:0];
        REG_WIDTH_MAX:       width_max_q  <= cfg_wdata_i[CoordW-1:0];
        REG_HEIGHT_MAX:      height_max_q <= cfg_wdata_i[CoordW-1:0];
        REG_SWAP_AXES:       swap_q       <= cfg_wdata_i[0];
        REG_MIRROR_H:        mirror_h_q   <= cfg_wdata_i[0];
        REG_MIRROR_V:        mirror_v_q   <= cfg_wdata_i[0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  // whole pipeline advances when the output register is free or being taken
  logic adv;
  logic out_valid_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 0: input register
  logic             v0_q;
  opcode_e          op0_q;
  logic [WordW-1:0] word0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op0_q   <= opcode_e'(s_axis_tuser);
      word0_q <= s_axis_tdata;
    end
  end

  // stage 1: frame state update
  logic [WordW-1:0]  first_q, first_d;
  logic [CoordW-1:0] frame_pres_q, frame_pres_d;
  logic              collect_q, collect_d;
  logic              skip_q, skip_d;
  logic [SumW-1:0]   sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [PairW-1:0]  pairs_q, pairs_d;

  logic              emit;
  logic              emit_touched;
  logic [CoordW-1:0] emit_pres;
  logic [ScaledW-1:0] emit_sx, emit_sy;
  logic [CoordW-1:0] pres_calc;
  logic [SumW-1:0]   sum_y_new;
  logic [PairW-1:0]  pairs_new;

  // ((z1 >> 3) + 4096 - (z2 >> 3)) wrapped to 16 bits
  assign pres_calc = CoordW'(first_q >> SumShift) + AdcFullScale
                   - CoordW'(word0_q >> SumShift);
  assign sum_y_new = sum_y_q + SumW'(word0_q);
  assign pairs_new = pairs_q + PairW'(1);

  always_comb begin
    first_d      = first_q;
    frame_pres_d = frame_pres_q;
    collect_d    = collect_q;
    skip_d       = skip_q;
    sum_x_d      = sum_x_q;
    sum_y_d      = sum_y_q;
    pairs_d      = pairs_q;
    emit         = 1'b0;
    emit_touched = 1'b0;
    emit_pres    = pres_calc;
    emit_sx      = '0;
    emit_sy      = '0;
    if (v0_q) begin
      unique case (op0_q)
        OP_Z1: first_d = word0_q;
        OP_Z2: begin
          collect_d = 1'b0;
          if (pres_calc < thr_q) begin
            // untouched report right away
            emit = 1'b1;
          end else begin
            frame_pres_d = pres_calc;
            collect_d    = 1'b1;
            skip_d       = 1'b1;
            sum_x_d      = '0;
            sum_y_d      = '0;
            pairs_d      = '0;
          end
        end
        OP_X: begin
          if (collect_q) begin
            if (skip_q) skip_d = 1'b0;
            else        sum_x_d = sum_x_q + SumW'(word0_q);
          end
        end
        OP_Y: begin
          if (collect_q) begin
            sum_y_d = sum_y_new;
            if (pairs_new == PairsLast) begin
              emit         = 1'b1;
              emit_touched = 1'b1;
              emit_pres    = frame_pres_q;
              emit_sx      = sum_x_q[SumW-1:SumShift];
              emit_sy      = sum_y_new[SumW-1:SumShift];
              collect_d    = 1'b0;
              skip_d       = 1'b0;
              pairs_d      = '0;
            end else begin
              pairs_d = pairs_new;
            end
          end
        end
        default: ;
      endcase
    end
  end

  logic               v1_q, t1_q;
  logic [CoordW-1:0]  p1_q;
  logic [ScaledW-1:0] sx1_q, sy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= '0;
      frame_pres_q <= '0;
      collect_q    <= 1'b0;
      skip_q       <= 1'b0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      pairs_q      <= '0;
      v1_q         <= 1'b0;
    end else if (adv) begin
      first_q      <= first_d;
      frame_pres_q <= frame_pres_d;
      collect_q    <= collect_d;
      skip_q       <= skip_d;
      sum_x_q      <= sum_x_d;
      sum_y_q      <= sum_y_d;
      pairs_q      <= pairs_d;
      v1_q         <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q  <= emit_touched;
      p1_q  <= emit_pres;
      sx1_q <= emit_sx;
      sy1_q <= emit_sy;
    end
  end

  // stage 2: (sum >> 3) * max, then drop the 12 adc bits
  logic [ProdW-1:0]  prod_x, prod_y;
  logic              v2_q, t2_q;
  logic [CoordW-1:0] p2_q;
  logic [QuotW-1:0]  ax2_q, ay2_q;

  assign prod_x = ProdW'(sx1_q) * ProdW'(width_max_q);
  assign prod_y = ProdW'(sy1_q) * ProdW'(height_max_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t2_q  <= t1_q;
      p2_q  <= p1_q;
      ax2_q <= prod_x[ProdW-1:AdcBits];
      ay2_q <= prod_y[ProdW-1:AdcBits];
    end
  end

  // stage 3: divide by the pair count through the reciprocal
  logic [RecipProdW-1:0] rq_x, rq_y;
  logic                  v3_q, t3_q;
  logic [CoordW-1:0]     p3_q, h3_q, vv3_q;

  assign rq_x = RecipProdW'(ax2_q) * RecipProdW'(Recip);
  assign rq_y = RecipProdW'(ay2_q) * RecipProdW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t3_q  <= t2_q;
      p3_q  <= p2_q;
      h3_q  <= rq_x[RecipShift +: CoordW];
      vv3_q <= rq_y[RecipShift +: CoordW];
    end
  end

  // stage 4: mirror, swap, output register
  logic [CoordW-1:0] h_m, v_m, pos_x_d, pos_y_d;
  logic              out_touched_q;
  logic [CoordW-1:0] out_x_q, out_y_q, out_p_q;

  assign h_m = mirror_h_q ? (width_max_q - h3_q) : h3_q;
  assign v_m = mirror_v_q ? (height_max_q - vv3_q) : vv3_q;

  always_comb begin
    if (!t3_q) begin
      pos_x_d = '0;
      pos_y_d = '0;
    end else if (swap_q) begin
      pos_x_d = v_m;
      pos_y_d = h_m;
    end else begin
      pos_x_d = h_m;
      pos_y_d = v_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_touched_q <= t3_q;
      out_x_q       <= pos_x_d;
      out_y_q       <= pos_y_d;
      out_p_q       <= p3_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_touched_q;
  assign m_axis_tdata  = {out_p_q, out_y_q, out_x_q};

`ifndef SYNTHESIS
  // an untouched report never carries coordinates
  a_untouched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[2*CoordW-1:0] == '0))
    else $error("untouched report with nonzero coordinates");

  // pair counter is cleared before it can reach the frame length
  a_pairs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pairs_q < PairsLast)
    else $error("pair counter overran frame length");

  // a touched report leaving the frame stage had passed the threshold
  a_touch_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && t1_q) |-> !(p1_q < thr_q))
    else $error("touched report below pressure threshold");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for the resistive touch sample processor.
// drives tagged converter words, predicts every touch report and compares.
// depends on rtsp_pkg and resistive_touch_sample_processor.
`timescale 1ns / 1ps

module tb_top;
  import rtsp_pkg::*;

  // bench constants
  localparam int unsigned SamplePairs = SamplePairsDef;
  localparam int unsigned PipeDepth   = 5;     // word to report, from the top level notes
  localparam int unsigned QuietLimit  = 3000;  // cycles with no handshake before giving up
  localparam logic [CfgAddrW-1:0] RegSpareLo = 3'd6;  // unmapped indexes, must be ignored
  localparam logic [CfgAddrW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic              touched;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pressure;
  } touch_report_t;

  typedef struct {
    logic [CoordW-1:0] thr;
    logic [CoordW-1:0] wmax;
    logic [CoordW-1:0] hmax;
    logic              swap;
    logic              mir_h;
    logic              mir_v;
  } panel_setup_t;

  // dut ports, the inputs all known from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [WordW-1:0]    s_axis_tdata  = '0;  // [15:0] raw_word
  logic [OpW-1:0]      s_axis_tuser  = '0;  // [1:0] opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [15:0] pos_x, [31:16] pos_y, [47:32] pressure
  logic                m_axis_tuser;        // [0] touched
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;

  // idling knobs, percent of cycles
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  int unsigned err_count = 0;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;

  // predicted reports, oldest first
  touch_report_t touch_reports_q[$];
  touch_report_t seen_report, due_report;

  // shadow of the config registers
  logic [CoordW-1:0] thr_q  = PressThresholdRst;
  logic [CoordW-1:0] wmax_q = WidthMaxRst;
  logic [CoordW-1:0] hmax_q = HeightMaxRst;
  logic swap_q = 1'b0, mir_h_q = 1'b0, mir_v_q = 1'b0;

  // shadow of the frame state
  logic [WordW-1:0]  z1_word     = '0;
  logic [CoordW-1:0] frame_press = '0;
  logic              pressed     = 1'b0;
  logic              drop_x      = 1'b0;
  logic [SumW-1:0]   acc_x       = '0;
  logic [SumW-1:0]   acc_y       = '0;
  int unsigned       y_count     = 0;

  resistive_touch_sample_processor u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // touch prediction
  // ---------------------------------------------------------------------------

  // average of the summed samples scaled to screen units, wrapped to 16 bits
  function automatic logic [CoordW-1:0] scale_coord(logic [SumW-1:0] sum,
                                                    logic [CoordW-1:0] full);
    logic [63:0] num;
    num = 64'(sum >> SumShift) * 64'(full);
    return CoordW'(num / (64'(AdcFullScale) * 64'(SamplePairs)));
  endfunction

  function automatic logic [CoordW-1:0] mirror_coord(logic on, logic [CoordW-1:0] full,
                                                     logic [CoordW-1:0] c);
    return on ? CoordW'(full - c) : c;
  endfunction

  // updates the frame shadow for one accepted word, queues any report it causes
  function automatic void track_touch_word(opcode_e op, logic [WordW-1:0] w);
    logic [CoordW-1:0] p, h, v;
    touch_report_t     r;
    case (op)
      OP_Z1: z1_word = w;
      OP_Z2: begin
        p = CoordW'(32'(z1_word >> SumShift) + 32'(AdcFullScale) - 32'(w >> SumShift));
        pressed = 1'b0;
        if (p < thr_q) begin
          // light press: untouched report right away
          r = '{touched: 1'b0, pos_x: '0, pos_y: '0, pressure: p};
          touch_reports_q.push_back(r);
        end else begin
          // firm press: open a frame, first x sample is thrown away
          frame_press = p;
          pressed = 1'b1;
          drop_x = 1'b1;
          acc_x = '0;
          acc_y = '0;
          y_count = 0;
        end
      end
      OP_X: begin
        if (pressed) begin
          if (drop_x) drop_x = 1'b0;
          else acc_x = acc_x + SumW'(w);
        end
      end
      OP_Y: begin
        if (pressed) begin
          acc_y = acc_y + SumW'(w);
          y_count++;
          if (y_count >= SamplePairs) begin
            h = scale_coord(acc_x, wmax_q);
            v = scale_coord(acc_y, hmax_q);
            r.touched = 1'b1;
            r.pressure = frame_press;
            if (swap_q) begin
              r.pos_x = mirror_coord(mir_v_q, hmax_q, v);
              r.pos_y = mirror_coord(mir_h_q, wmax_q, h);
            end else begin
              r.pos_x = mirror_coord(mir_h_q, wmax_q, h);
              r.pos_y = mirror_coord(mir_v_q, hmax_q, v);
            end
            touch_reports_q.push_back(r);
            pressed = 1'b0;
            drop_x = 1'b0;
            y_count = 0;
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // report checking and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(string what, logic [CoordW-1:0] got, logic [CoordW-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    // stall pattern for the next cycle
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_report.touched  = m_axis_tuser;
      seen_report.pos_x    = m_axis_tdata[CoordW-1:0];
      seen_report.pos_y    = m_axis_tdata[2*CoordW-1:CoordW];
      seen_report.pressure = m_axis_tdata[3*CoordW-1:2*CoordW];
      if (touch_reports_q.size() == 0) begin
        note_mismatch("report with none pending, pressure", seen_report.pressure, '0);
      end else begin
        due_report = touch_reports_q.pop_front();
        if (seen_report.touched != due_report.touched)
          note_mismatch("touched", CoordW'(seen_report.touched), CoordW'(due_report.touched));
        if (seen_report.pos_x != due_report.pos_x)
          note_mismatch("pos_x", seen_report.pos_x, due_report.pos_x);
        if (seen_report.pos_y != due_report.pos_y)
          note_mismatch("pos_y", seen_report.pos_y, due_report.pos_y);
        if (seen_report.pressure != due_report.pressure)
          note_mismatch("pressure", seen_report.pressure, due_report.pressure);
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one request on the input stream; tvalid stays up unless a gap is drawn
  task automatic send_word(opcode_e op, logic [WordW-1:0] w);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    track_touch_word(op, w);
    words_sent++;
  endtask

  // sender holds off until every pending report is out
  task automatic wait_reports_drained();
    s_axis_tvalid <= 1'b0;
    while (touch_reports_q.size() != 0) @(posedge clk_i);
  endtask

  // fully idle: words that cause no report may still be in the pipe
  task automatic settle();
    wait_reports_drained();
    repeat (PipeDepth + 3) @(posedge clk_i);
  endtask

  // leaves the write enable high so back-to-back writes need no toggle
  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_PRESS_THRESHOLD: thr_q   = val;
      REG_WIDTH_MAX:       wmax_q  = val;
      REG_HEIGHT_MAX:      hmax_q  = val;
      REG_SWAP_AXES:       swap_q  = val[0];
      REG_MIRROR_H:        mir_h_q = val[0];
      REG_MIRROR_V:        mir_v_q = val[0];
      default: ;  // unmapped index, no effect
    endcase
  endtask

  // only called while settled; one-bit registers get junk in the upper bits
  task automatic apply_setup(panel_setup_t s);
    write_reg(RegSpareLo, CfgDataW'($urandom));
    write_reg(REG_PRESS_THRESHOLD, s.thr);
    write_reg(REG_WIDTH_MAX, s.wmax);
    write_reg(REG_HEIGHT_MAX, s.hmax);
    write_reg(REG_SWAP_AXES, {15'($urandom), s.swap});
    write_reg(REG_MIRROR_H, {15'($urandom), s.mir_h});
    write_reg(REG_MIRROR_V, {15'($urandom), s.mir_v});
    write_reg(RegSpareHi, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // z2 word: often aimed at the threshold or just below it
  function automatic logic [WordW-1:0] pick_z2(logic [WordW-1:0] z1w);
    logic [31:0]       b;
    logic [CoordW-1:0] target;
    if ($urandom_range(3) != 0) return WordW'($urandom);
    target = thr_q - CoordW'($urandom_range(1));
    b = (32'(z1w >> SumShift) + 32'(AdcFullScale) - 32'(target)) & 32'hFFFF;
    if (b > 32'd8191) return WordW'($urandom);
    return {b[12:0], 3'($urandom)};
  endfunction

  // mostly clean frames with random samples, some noise and broken frames
  task automatic send_frame();
    int unsigned     pick;
    logic [WordW-1:0] z1w;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 6)) send_word(opcode_e'($urandom_range(3)), WordW'($urandom));
    end else begin
      z1w = WordW'($urandom);
      send_word(OP_Z1, z1w);
      send_word(OP_Z2, pick_z2(z1w));
      if (pick < 22) begin
        // truncated or lopsided frame, next z2 cuts it off
        repeat ($urandom_range(0, 7))
          send_word($urandom_range(1) ? OP_X : OP_Y, WordW'($urandom));
      end else begin
        send_word(OP_X, WordW'($urandom));
        repeat (SamplePairs) begin
          send_word(OP_X, WordW'($urandom));
          send_word(OP_Y, WordW'($urandom));
        end
      end
    end
  endtask

  task automatic send_frames(int unsigned n_words);
    int unsigned stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) send_frame();
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
      default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-built words at reset config: threshold edges, dropped x, abandon, ignore
  task automatic test_directed();
    set_idling(0);
    send_word(OP_X, 16'h1234);        // outside a frame, ignored
    send_word(OP_Y, 16'hFFFF);
    send_word(OP_Z1, 16'h0000);
    send_word(OP_Z2, 16'h7FF8);       // pressure 1, untouched
    send_word(OP_Z2, 16'd27976);      // pressure one below threshold
    send_word(OP_Z2, 16'd27968);      // pressure at threshold opens a frame
    send_word(OP_Z1, 16'hFFFF);       // latched only, frame stays open
    send_word(OP_Y, 16'h8000);        // y ahead of the dropped x still counts
    send_word(OP_X, 16'hFFFF);        // dropped
    send_word(OP_X, 16'hFFFF);
    send_word(OP_X, 16'h0001);        // repeated x, both kept
    send_word(OP_Y, 16'h7FFF);
    send_word(OP_Y, 16'hFFFF);
    send_word(OP_Y, 16'h0000);        // last pair closes the frame
    send_word(OP_Z2, 16'h0000);       // max pressure, new frame
    send_word(OP_X, 16'h0000);        // dropped
    send_word(OP_Z2, 16'hFFFF);       // abandons the open frame
    send_word(OP_X, 16'h5555);        // dropped
    repeat (SamplePairs) begin
      send_word(OP_X, 16'hFFFF);
      send_word(OP_Y, 16'hFFFF);
    end
    settle();
  endtask

  // register extremes and axis options, cycling through the idling modes
  task automatic test_config_sweep();
    panel_setup_t sweep[8];
    sweep[0] = '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0};
    sweep[1] = '{16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1};
    sweep[2] = '{16'd600,  16'd320,  16'd240,  1'b1, 1'b0, 1'b0};
    sweep[3] = '{16'h0000, 16'd320,  16'd240,  1'b0, 1'b1, 1'b0};
    sweep[4] = '{16'd1000, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1};
    sweep[5] = '{16'h8000, 16'd800,  16'd480,  1'b1, 1'b1, 1'b0};
    sweep[6] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1};
    sweep[7] = '{16'd1,    16'd1,    16'd1,    1'b0, 1'b1, 1'b1};
    for (int i = 0; i < 8; i++) begin
      apply_setup(sweep[i]);
      set_idling(i);
      send_frames(50);
      settle();
    end
  endtask

  // long random traffic per idling mode with a random panel setup
  task automatic test_idle_phases();
    panel_setup_t s;
    for (int m = 0; m < 4; m++) begin
      s.thr   = CoordW'($urandom_range(0, 3000));
      s.wmax  = CoordW'($urandom);
      s.hmax  = CoordW'($urandom);
      s.swap  = 1'($urandom);
      s.mir_h = 1'($urandom);
      s.mir_v = 1'($urandom);
      apply_setup(s);
      set_idling(m);
      send_frames(75);
      // sender holds off until the output side has caught up
      wait_reports_drained();
      send_frames(75);
      settle();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_idle_phases();
    set_idling(0);
    settle();
    repeat (4 * PipeDepth) @(posedge clk_i);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rtsp_pkg.sv
rtl/resistive_touch_sample_processor.sv
test/tb_top.sv
